/* rtl/mse_pkg.sv */
// Shared types and codes for the matrix square entry block.
// No dependencies; every other file imports this package.
package mse_pkg;

    // Widths fixed by the item fields
    localparam int IDX_W   = 4;
    localparam int SIZE_W  = 5;
    localparam int DATA_W  = 32;
    localparam int ENTRY_W = 8;

    typedef logic [IDX_W-1:0]          idx_t;
    typedef logic [SIZE_W-1:0]         size_t;
    typedef logic signed [DATA_W-1:0]  data_t;
    typedef logic [ENTRY_W-1:0]        entry_t;
    typedef logic                      mode_t;

    // Item modes
    localparam mode_t MODE_LOAD    = 1'b0;
    localparam mode_t MODE_COMPUTE = 1'b1;

    // Size register after reset
    localparam size_t SIZE_RESET = 5'd16;

    // Control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clear;   // zero the accumulator
        logic load;    // operand pair valid this cycle
    } mac_ctrl_t;

    // Status back from the multiply-accumulate unit
    typedef struct packed {
        logic busy;    // a product still waits to be added
    } mac_stat_t;

endpackage

/* rtl/mse_if.sv */
// Valid/ready channel interfaces for input items and result items.
// Depends on mse_pkg.
interface mse_item_if;
    import mse_pkg::*;

    logic   valid;
    logic   ready;
    mode_t  mode;
    idx_t   row_index;
    idx_t   col_index;
    data_t  element_value;

    modport source (output valid, output mode, output row_index, output col_index,
                    output element_value, input ready);
    modport sink   (input valid, input mode, input row_index, input col_index,
                    input element_value, output ready);
endinterface

interface mse_result_if;
    import mse_pkg::*;

    logic   valid;
    logic   ready;
    data_t  product_value;
    entry_t entry_index;

    modport source (output valid, output product_value, output entry_index, input ready);
    modport sink   (input valid, input product_value, input entry_index, output ready);
endinterface

/* rtl/mse_store.sv */
// Matrix element memory: one write port, two registered read ports.
// Depends on mse_pkg.
module mse_store #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  mse_pkg::data_t      wr_data,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr_a,
    input  logic [ADDR_W-1:0]   rd_addr_b,
    output mse_pkg::data_t      rd_data_a,
    output mse_pkg::data_t      rd_data_b
);
    import mse_pkg::*;

    data_t mem [DEPTH];
    data_t rd_a_reg;
    data_t rd_b_reg;

    // Write one element
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read the row element and the column element
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

/* rtl/mse_mac.sv */
// Shared multiply-accumulate unit: registered product, then 32-bit wrapping sum.
// Depends on mse_pkg.
module mse_mac (
    input  logic               clk,
    input  logic               rst_n,
    input  mse_pkg::mac_ctrl_t ctrl,
    input  mse_pkg::data_t     op_a,
    input  mse_pkg::data_t     op_b,
    output mse_pkg::data_t     acc,
    output mse_pkg::mac_stat_t stat
);
    import mse_pkg::*;

    logic [DATA_W-1:0]   prod_low;
    data_t               prod_reg;
    logic                prod_valid_reg;
    data_t               acc_reg;

    // Low half of the product is the same signed or unsigned
    assign prod_low = unsigned'(op_a) * unsigned'(op_b);

    // Register the product
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            prod_reg <= data_t'(prod_low);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= ctrl.load;
        end
    end

    // Clear or add the waiting product, wrapping at 32 bits
    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (prod_valid_reg)
        begin
            acc_reg <= acc_reg + prod_reg;
        end
    end

    assign acc       = acc_reg;
    assign stat.busy = prod_valid_reg;

endmodule

/* rtl/matrix_square_entry.sv */
// Load item: written in the cycle it is accepted, one item per cycle while the block is idle.
// Compute item: one element pair read from the two-port store per cycle into one shared
// multiply-accumulate unit. Row or column outside the size in use: no reads, value 0.
// Not ready during a compute, and later still while an earlier result waits.
// Reset: size 16, sequencer idle, no result, store undefined.
module matrix_square_entry #(
    parameter int MAX_SIZE = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_wr_en,
    input  mse_pkg::size_t  cfg_wr_data,
    mse_item_if.sink        item,
    mse_result_if.source    result
);
    import mse_pkg::*;

    localparam int DEPTH  = MAX_SIZE * MAX_SIZE;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Sequencer states
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RUN    = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]        state_reg, state_next;
    size_t             size_reg;
    size_t             size_eff;
    size_t             k_reg, k_next;
    idx_t              row_reg, col_reg;
    entry_t            entry_reg;
    logic              rd_valid_reg;
    logic              out_valid_reg;
    data_t             out_value_reg;
    entry_t            out_entry_reg;

    logic              accept;
    logic              in_range;
    logic              load_in_store;
    logic              last_k;
    logic              out_free;
    entry_t            entry_calc;
    logic [ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;
    data_t             rd_data_a, rd_data_b;
    data_t             acc;
    mac_ctrl_t         mac_ctrl;
    mac_stat_t         mac_stat;

    // Clamp the size register into 1 .. MAX_SIZE
    always_comb
    begin
        if (size_reg == '0)
        begin
            size_eff = size_t'(1);
        end
        else if (32'(size_reg) > MAX_SIZE)
        begin
            size_eff = size_t'(MAX_SIZE);
        end
        else
        begin
            size_eff = size_reg;
        end
    end

    assign item.ready    = (state_reg == ST_IDLE);
    assign accept        = item.valid && item.ready;
    assign in_range      = (32'(item.row_index) < 32'(size_eff))
                        && (32'(item.col_index) < 32'(size_eff));
    assign load_in_store = (32'(item.row_index) < MAX_SIZE)
                        && (32'(item.col_index) < MAX_SIZE);
    assign entry_calc    = entry_t'(32'(item.row_index) * 32'(size_eff)
                                    + 32'(item.col_index));
    assign last_k        = (k_reg == size_t'(size_eff - size_t'(1)));
    assign out_free      = !out_valid_reg || result.ready;

    // Store addresses: row-major with a fixed row pitch of MAX_SIZE
    assign wr_addr   = ADDR_W'(32'(item.row_index) * MAX_SIZE + 32'(item.col_index));
    assign rd_addr_a = ADDR_W'(32'(row_reg) * MAX_SIZE + 32'(k_reg));
    assign rd_addr_b = ADDR_W'(32'(k_reg) * MAX_SIZE + 32'(col_reg));

    mse_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk       (clk),
        .wr_en     (accept && (item.mode == MODE_LOAD) && load_in_store),
        .wr_addr   (wr_addr),
        .wr_data   (item.element_value),
        .rd_en     (state_reg == ST_RUN),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    assign mac_ctrl.clear = accept && (item.mode == MODE_COMPUTE);
    assign mac_ctrl.load  = rd_valid_reg;

    mse_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .op_a  (rd_data_a),
        .op_b  (rd_data_b),
        .acc   (acc),
        .stat  (mac_stat)
    );

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (item.mode == MODE_COMPUTE))
                begin
                    k_next     = '0;
                    state_next = in_range ? ST_RUN : ST_FINISH;
                end
            end
            ST_RUN:
            begin
                k_next = size_t'(k_reg + size_t'(1));
                if (last_k)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_valid_reg && !mac_stat.busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            size_reg      <= SIZE_RESET;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            k_reg        <= k_next;
            rd_valid_reg <= (state_reg == ST_RUN);
            if (cfg_wr_en)
            begin
                size_reg <= cfg_wr_data;
            end
            // Fill the result register, drop it after transfer
            if ((state_reg == ST_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the compute item's indices and flat position, and fill the result value and entry
    always_ff @(posedge clk)
    begin
        if (accept && (item.mode == MODE_COMPUTE))
        begin
            row_reg   <= item.row_index;
            col_reg   <= item.col_index;
            entry_reg <= entry_calc;
        end
        if ((state_reg == ST_FINISH) && out_free)
        begin
            out_value_reg <= acc;
            out_entry_reg <= entry_reg;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.product_value = out_value_reg;
    assign result.entry_index   = out_entry_reg;

endmodule

/* rtl/mse_check.sv */
// Port-level checks for matrix_square_entry, attached with a bind.
// Depends on mse_pkg and the top level's ports.
module mse_check (
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input mse_pkg::mode_t  in_mode,
    input logic            out_valid,
    input logic            out_ready
);
    import mse_pkg::*;

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A compute transfer makes the block busy
    a_busy_after_compute: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_mode == MODE_COMPUTE) |=> !in_ready)
        else $error("ready after compute transfer");

    // A load transfer produces no result
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_mode == MODE_LOAD) && !out_valid |=> !out_valid)
        else $error("result after load transfer");

    // A new result appears only at the end of a compute
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared while idle");

endmodule

bind matrix_square_entry mse_check u_mse_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .in_mode   (item.mode),
    .out_valid (result.valid),
    .out_ready (result.ready)
);

/* bench/tb.sv */
// Self-checking bench for matrix_square_entry: loads elements, computes entries of the
// square, and checks every result against an in-bench predictor through a scoreboard class.
// Depends on mse_pkg, mse_if (mse_item_if, mse_result_if) and the matrix_square_entry RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mse_pkg::*;

    localparam int STORE_DIM    = 16;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 36;

    typedef struct {
        data_t  product;
        entry_t entry;
    } square_entry_t;

    // Predicts each entry of the square and holds the entries still to arrive
    class square_tracker;
        logic [DATA_W-1:0] store [STORE_DIM*STORE_DIM];
        size_t             size_reg;
        square_entry_t     pending_entries [$];
        int                errors;

        function new();
            size_reg = SIZE_RESET;
            errors   = 0;
            foreach (store[i]) store[i] = '0;
        endfunction

        function void set_size(size_t v);
            size_reg = v;
        endfunction

        // Clamp the register to the range the store supports
        function int unsigned live_size();
            if (size_reg == 0)
                return 1;
            if (size_reg > STORE_DIM)
                return STORE_DIM;
            return 32'(size_reg);
        endfunction

        function int outstanding();
            return pending_entries.size();
        endfunction

        // Note an accepted transfer: write the element, or queue the predicted entry
        function void note_item(mode_t mode, idx_t r, idx_t c, data_t v);
            square_entry_t     e;
            int unsigned       n;
            logic [DATA_W-1:0] acc;
            if (mode == MODE_LOAD)
            begin
                store[r*STORE_DIM + c] = v;
                return;
            end
            n   = live_size();
            acc = '0;
            if (r < n && c < n)
            begin
                for (int k = 0; k < n; k++)
                    acc = acc + store[r*STORE_DIM + k] * store[k*STORE_DIM + c];
            end
            e.product = acc;
            e.entry   = entry_t'(r*n + c);
            pending_entries.push_back(e);
        endfunction

        // Compare one accepted result with the oldest predicted entry
        function void check_entry(data_t product, entry_t entry);
            square_entry_t e;
            if (pending_entries.size() == 0)
            begin
                $error("unexpected result: product_value %0d entry_index %0d", product, entry);
                errors++;
                return;
            end
            e = pending_entries.pop_front();
            if (product !== e.product)
            begin
                $error("product_value: expected %0d, actual %0d", e.product, product);
                errors++;
            end
            if (entry !== e.entry)
            begin
                $error("entry_index: expected %0d, actual %0d", e.entry, entry);
                errors++;
            end
        endfunction
    endclass

    logic          clk = 1'b0;
    logic          rst_n;
    logic          cfg_wr_en;
    size_t         cfg_wr_data;
    bit            written [STORE_DIM*STORE_DIM];
    bit            steady;
    bit            press_go;
    bit            press_done;
    square_tracker sb;

    mse_item_if   item_ch ();
    mse_result_if result_ch ();

    matrix_square_entry #(
        .MAX_SIZE (STORE_DIM)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (item_ch),
        .result      (result_ch)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6)
            return 0;
        if (roll < 9)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Element values biased towards the signed extremes
    function automatic data_t rand_word();
        case ($urandom_range(0, 7))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Offer one item and hold it until the transfer
    task automatic push_item(mode_t mode, idx_t r, idx_t c, data_t v);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            item_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.valid         = 1'b1;
        item_ch.mode          = mode;
        item_ch.row_index     = r;
        item_ch.col_index     = c;
        item_ch.element_value = v;
        do
            @(posedge clk);
        while (item_ch.ready !== 1'b1);
        sb.note_item(mode, r, c, v);
        if (mode == MODE_LOAD)
            written[r*STORE_DIM + c] = 1'b1;
        @(negedge clk);
    endtask

    // Write the size register once the block has gone idle
    task automatic write_size(size_t v);
        item_ch.valid = 1'b0;
        while (sb.outstanding() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        sb.set_size(v);
    endtask

    // Load every element that the entry (r, c) reads and that is still unwritten
    task automatic fill_operands(idx_t r, idx_t c);
        int unsigned n;
        n = sb.live_size();
        for (int k = 0; k < n; k++)
        begin
            if (!written[r*STORE_DIM + k])
                push_item(MODE_LOAD, r, idx_t'(k), rand_word());
            if (!written[k*STORE_DIM + c])
                push_item(MODE_LOAD, idx_t'(k), c, rand_word());
        end
    endtask

    // Mostly well-formed computes inside the size, plus stray loads and any-index computes
    task automatic random_item();
        int          pick;
        int unsigned n;
        idx_t        r;
        idx_t        c;
        pick = $urandom_range(0, 19);
        n    = sb.live_size();
        if (pick < 12)
        begin
            r = idx_t'($urandom_range(0, n - 1));
            c = idx_t'($urandom_range(0, n - 1));
            fill_operands(r, c);
            push_item(MODE_COMPUTE, r, c, $urandom);
        end
        else if (pick < 17)
        begin
            push_item(MODE_LOAD, idx_t'($urandom_range(0, 15)), idx_t'($urandom_range(0, 15)),
                      rand_word());
        end
        else
        begin
            r = idx_t'($urandom_range(0, 15));
            c = idx_t'($urandom_range(0, 15));
            if (r < n && c < n)
                fill_operands(r, c);
            push_item(MODE_COMPUTE, r, c, $urandom);
        end
    endtask

    // Result ready: random stalls, one long hold-off, steady stretches
    initial
    begin
        int stall;
        stall           = 0;
        press_done      = 1'b0;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (press_go && !press_done)
            begin
                result_ch.ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                press_done = 1'b1;
            end
            else if (steady)
                result_ch.ready = 1'b1;
            else if (stall > 0)
            begin
                result_ch.ready = 1'b0;
                stall--;
            end
            else if ($urandom_range(0, 9) < 2)
            begin
                result_ch.ready = 1'b0;
                stall = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3)
                                                    : $urandom_range(10, 40);
            end
            else
                result_ch.ready = 1'b1;
        end
    end

    // Check each result transfer
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
                sb.check_entry(result_ch.product_value, result_ch.entry_index);
        end
    end

    // Stimulus
    initial
    begin
        data_t extremes [5];
        size_t phase_sizes [8];
        extremes    = '{32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd1, 32'sd0, 32'sd1};
        phase_sizes = '{5'd31, 5'd1, 5'd0, 5'd16, 5'd9, 5'd2, 5'd5, 5'd12};
        sb                    = new();
        steady                = 1'b0;
        press_go              = 1'b0;
        rst_n                 = 1'b0;
        cfg_wr_en             = 1'b0;
        cfg_wr_data           = '0;
        item_ch.valid         = 1'b0;
        item_ch.mode          = MODE_LOAD;
        item_ch.row_index     = '0;
        item_ch.col_index     = '0;
        item_ch.element_value = '0;
        foreach (written[i]) written[i] = 1'b0;

        // Hold reset, then release on a falling edge
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Directed: a 4 x 4 matrix of extreme values
        write_size(5'd4);
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                push_item(MODE_LOAD, idx_t'(r), idx_t'(c), extremes[(r*4 + c) % 5]);
        // Loads outside the size in use still land in the store
        push_item(MODE_LOAD, 4'd15, 4'd15, 32'sh8000_0000);
        push_item(MODE_LOAD, 4'd4, 4'd0, 32'sh7FFF_FFFF);
        push_item(MODE_COMPUTE, 4'd0, 4'd0, 32'sh7FFF_FFFF);
        push_item(MODE_COMPUTE, 4'd3, 4'd3, 32'sh8000_0000);
        push_item(MODE_COMPUTE, 4'd1, 4'd2, -32'sd1);
        push_item(MODE_COMPUTE, 4'd2, 4'd1, 32'sd0);
        // Computes outside the size give zero
        push_item(MODE_COMPUTE, 4'd15, 4'd15, 32'sd0);
        push_item(MODE_COMPUTE, 4'd3, 4'd9, 32'sd0);
        push_item(MODE_COMPUTE, 4'd9, 4'd3, 32'sd0);

        // Random phases over several sizes, clamped ones among them
        for (int p = 0; p < 8; p++)
        begin
            write_size(phase_sizes[p]);
            steady = (p == 3 || p == 6);
            if (p == 0)
                press_go = 1'b1;
            repeat (PHASE_ITEMS) random_item();
        end

        // Drain and report
        item_ch.valid = 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("[matrix_square_entry] OK");
        else
            $display("[matrix_square_entry] ERROR");
        $finish;
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("[matrix_square_entry] ERROR");
        $finish;
    end

endmodule

/* matrix_square_entry.f */
rtl/mse_pkg.sv
rtl/mse_if.sv
rtl/mse_store.sv
rtl/mse_mac.sv
rtl/matrix_square_entry.sv
rtl/mse_check.sv
bench/tb.sv
